// ===== design/tahs_pkg.sv =====
// Shared types, constants and helpers for the three-axis homing sequencer.
package tahs_pkg;

    localparam int JOINTS       = 3;
    localparam int DELAY_W      = 16;
    localparam int MAX_SEEK_W   = 20;
    localparam int SEEK_CNT_W   = 21;
    localparam int BACKOFF_W    = 16;
    localparam int BACKOFF_CNT_W = 17;
    localparam int PHASE_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    // Input kinds carried on s_axis_tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Phase codes as reported on the result stream
    localparam logic [PHASE_W-1:0] CODE_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_SEEK     = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_BACKOFF  = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_COMPLETE = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_FAILED   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEEK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_DIRS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_TWO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_THREE = 3'd5;

    // Configuration reset values
    localparam logic [DELAY_W-1:0]    RST_STEP_DELAY = 16'd1000;
    localparam logic [MAX_SEEK_W-1:0] RST_MAX_SEEK   = 20'd10000;
    localparam logic [JOINTS-1:0]     RST_SEEK_DIRS  = 3'd3;
    localparam logic [BACKOFF_W-1:0]  RST_BACKOFF    = 16'd200;

    localparam logic [DELAY_W-1:0]       DELAY_SAT   = '1;
    localparam logic [BACKOFF_CNT_W-1:0] BACKOFF_SAT = '1;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SEEK     = 5'b00010,
        PH_BACKOFF  = 5'b00100,
        PH_COMPLETE = 5'b01000,
        PH_FAILED   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [DELAY_W-1:0]                step_delay;
        logic [MAX_SEEK_W-1:0]             max_seek;
        logic [JOINTS-1:0]                 seek_dirs;
        logic [JOINTS-1:0][BACKOFF_W-1:0]  backoff_steps;
    } cfg_t;

    typedef struct packed {
        logic              finished;
        logic              start_accepted;
        logic [PHASE_W-1:0] phase;
        logic [JOINTS-1:0] directions;
        logic [JOINTS-1:0] step_pulses;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_IDLE:     code = CODE_IDLE;
            PH_SEEK:     code = CODE_SEEK;
            PH_BACKOFF:  code = CODE_BACKOFF;
            PH_COMPLETE: code = CODE_COMPLETE;
            PH_FAILED:   code = CODE_FAILED;
            default:     code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/tahs_core.sv =====
// Homing state registers and the per-beat update of seek, backoff and timing.
module tahs_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         beat_en,
    input  logic                         action,
    input  logic [tahs_pkg::JOINTS-1:0]  switches,
    input  tahs_pkg::cfg_t               cfg,
    output tahs_pkg::result_t            result
);
    import tahs_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [JOINTS-1:0]        hit_reg, hit_next;
    logic [SEEK_CNT_W-1:0]    seek_cnt_reg, seek_cnt_next;
    logic [BACKOFF_CNT_W-1:0] backoff_cnt_reg, backoff_cnt_next;
    logic [DELAY_W-1:0]       elapsed_reg, elapsed_next;
    logic [JOINTS-1:0]        dir_reg, dir_next;

    logic                     busy;
    logic [DELAY_W-1:0]       elapsed_inc;
    logic [SEEK_CNT_W-1:0]    seek_inc;
    logic [JOINTS-1:0]        hit_upd;
    logic [JOINTS-1:0]        pulses;
    logic                     accepted;

    assign busy        = (phase_reg == PH_SEEK) || (phase_reg == PH_BACKOFF);
    assign elapsed_inc = (elapsed_reg != DELAY_SAT) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign seek_inc    = seek_cnt_reg + 1'b1;
    assign hit_upd     = hit_reg | (switches & ~hit_reg);

    // Advance the sequence by one beat
    always_comb begin
        phase_next       = phase_reg;
        hit_next         = hit_reg;
        seek_cnt_next    = seek_cnt_reg;
        backoff_cnt_next = backoff_cnt_reg;
        elapsed_next     = elapsed_reg;
        dir_next         = dir_reg;
        pulses           = '0;
        accepted         = 1'b0;
        if (beat_en) begin
            if (action == ACT_START) begin
                if (!busy) begin
                    hit_next         = '0;
                    seek_cnt_next    = '0;
                    backoff_cnt_next = '0;
                    elapsed_next     = '0;
                    dir_next         = cfg.seek_dirs;
                    phase_next       = PH_SEEK;
                    accepted         = 1'b1;
                end
            end else if (busy) begin
                if (elapsed_inc >= cfg.step_delay) begin
                    // Step opportunity
                    elapsed_next = '0;
                    if (phase_reg == PH_SEEK) begin
                        seek_cnt_next = seek_inc;
                        if (seek_inc > {1'b0, cfg.max_seek}) begin
                            phase_next = PH_FAILED;
                        end else begin
                            pulses   = ~hit_reg;
                            hit_next = hit_upd;
                            if (&hit_upd) begin
                                dir_next   = ~dir_reg;
                                phase_next = PH_BACKOFF;
                            end
                        end
                    end else begin
                        for (int j = 0; j < JOINTS; j++) begin
                            pulses[j] = backoff_cnt_reg < {1'b0, cfg.backoff_steps[j]};
                        end
                        if (backoff_cnt_reg != BACKOFF_SAT) begin
                            backoff_cnt_next = backoff_cnt_reg + 1'b1;
                        end
                        if (pulses == '0) begin
                            phase_next = PH_COMPLETE;
                        end
                    end
                end else begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
    end

    // Hold state between beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            hit_reg         <= '0;
            seek_cnt_reg    <= '0;
            backoff_cnt_reg <= '0;
            elapsed_reg     <= '0;
            dir_reg         <= '0;
        end else begin
            phase_reg       <= phase_next;
            hit_reg         <= hit_next;
            seek_cnt_reg    <= seek_cnt_next;
            backoff_cnt_reg <= backoff_cnt_next;
            elapsed_reg     <= elapsed_next;
            dir_reg         <= dir_next;
        end
    end

    // Build the result of this beat from the updated state
    always_comb begin
        result.step_pulses    = pulses;
        result.directions     = dir_next;
        result.phase          = phase_code(phase_next);
        result.start_accepted = accepted;
        result.finished       = (phase_next == PH_COMPLETE) || (phase_next == PH_FAILED);
    end

endmodule

// ===== design/three_axis_homing_sequencer.sv =====
// Top level of the three-axis homing sequencer: config bank, stream ports, result register.
//
//  channel   direction  carries
//  s_axis    in         tuser: action (0 start, 1 tick); tdata: limit switches
//  m_axis    out        tdata: pulses, directions, phase, start accepted, finished
//  cfg       in         write enable, register index, write data
//
// Every input beat yields one result beat; the state update and the result are registered together.
// A beat is taken each cycle while the result register is empty or being drained.
// Reset (aresetn low, synchronous) returns to idle and loads the default settings.
// A stall on m_axis holds the result register and drops s_axis_tready.
module three_axis_homing_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tahs_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [2:0] limit_switches
    input  logic                                s_axis_tuser,  // [0] action
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] step_pulses, [5:3] directions, [8:6] phase, [9] start_accepted, [10] finished
    output logic [tahs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [tahs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tahs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tahs_pkg::*;

    cfg_t                 cfg_reg;
    logic                 m_valid_reg;
    result_t              m_data_reg;
    logic                 in_beat;
    result_t              result;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_delay    <= RST_STEP_DELAY;
            cfg_reg.max_seek      <= RST_MAX_SEEK;
            cfg_reg.seek_dirs     <= RST_SEEK_DIRS;
            cfg_reg.backoff_steps <= {JOINTS{RST_BACKOFF}};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_DELAY:    cfg_reg.step_delay       <= cfg_wdata[DELAY_W-1:0];
                REG_MAX_SEEK:      cfg_reg.max_seek         <= cfg_wdata[MAX_SEEK_W-1:0];
                REG_SEEK_DIRS:     cfg_reg.seek_dirs        <= cfg_wdata[JOINTS-1:0];
                REG_BACKOFF_ONE:   cfg_reg.backoff_steps[0] <= cfg_wdata[BACKOFF_W-1:0];
                REG_BACKOFF_TWO:   cfg_reg.backoff_steps[1] <= cfg_wdata[BACKOFF_W-1:0];
                REG_BACKOFF_THREE: cfg_reg.backoff_steps[2] <= cfg_wdata[BACKOFF_W-1:0];
                default: ;
            endcase
        end
    end

    tahs_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_en  (in_beat),
        .action   (s_axis_tuser),
        .switches (s_axis_tdata[JOINTS-1:0]),
        .cfg      (cfg_reg),
        .result   (result)
    );

    // Hold the result until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, m_data_reg};

endmodule

// ===== verif/homing_checker.sv =====
// Scoreboard for the homing sequencer: mirrors its state, predicts each result beat and checks it.
module homing_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [tahs_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [2:0] limit_switches
    input  logic                            s_axis_tuser,   // [0] action
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] step_pulses, [5:3] directions, [8:6] phase, [9] start_accepted, [10] finished
    input  logic [tahs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_wr_en,
    input  logic [tahs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tahs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatch_total,
    output int                              reports_awaited
);
    import tahs_pkg::*;

    // Mirrored settings
    logic [DELAY_W-1:0]       delay_set;
    logic [MAX_SEEK_W-1:0]    seek_limit;
    logic [JOINTS-1:0]        seek_dir_set;
    logic [BACKOFF_W-1:0]     backoff_set [JOINTS];

    // Mirrored sequencer state
    logic [PHASE_W-1:0]       homing_phase;
    logic [JOINTS-1:0]        latched;
    logic [SEEK_CNT_W-1:0]    seek_steps;
    logic [BACKOFF_CNT_W-1:0] backoff_steps_done;
    logic [DELAY_W-1:0]       ticks_since_step;
    logic [JOINTS-1:0]        dir_level;

    // Result beats predicted but not yet seen
    result_t                  expected_reports [$];

    initial begin
        mismatch_total  = 0;
        reports_awaited = 0;
    end

    task automatic reset_homing();
        int j;
        delay_set    = RST_STEP_DELAY;
        seek_limit   = RST_MAX_SEEK;
        seek_dir_set = RST_SEEK_DIRS;
        for (j = 0; j < JOINTS; j++) backoff_set[j] = RST_BACKOFF;
        homing_phase       = CODE_IDLE;
        latched            = '0;
        seek_steps         = '0;
        backoff_steps_done = '0;
        ticks_since_step   = '0;
        dir_level          = '0;
    endtask

    // Apply one input beat to the mirrored state and build the result it produces
    task automatic advance_homing(input logic act, input logic [JOINTS-1:0] sw,
                                  output result_t res);
        logic [JOINTS-1:0] pulses;
        logic              took_start;
        int                j;
        pulses     = '0;
        took_start = 1'b0;
        if (act == ACT_START) begin
            // a start is refused while seeking or backing off
            if (homing_phase != CODE_SEEK && homing_phase != CODE_BACKOFF) begin
                latched            = '0;
                seek_steps         = '0;
                backoff_steps_done = '0;
                ticks_since_step   = '0;
                dir_level          = seek_dir_set;
                homing_phase       = CODE_SEEK;
                took_start         = 1'b1;
            end
        end else if (homing_phase == CODE_SEEK || homing_phase == CODE_BACKOFF) begin
            if (ticks_since_step != '1) ticks_since_step++;
            if (ticks_since_step >= delay_set) begin
                ticks_since_step = '0;
                if (homing_phase == CODE_SEEK) begin
                    seek_steps++;
                    if (seek_steps > SEEK_CNT_W'(seek_limit)) begin
                        homing_phase = CODE_FAILED;
                    end else begin
                        // pulse every joint still hunting, then latch its switch
                        for (j = 0; j < JOINTS; j++) begin
                            if (!latched[j]) begin
                                pulses[j]  = 1'b1;
                                latched[j] = sw[j];
                            end
                        end
                        if (&latched) begin
                            dir_level    = ~dir_level;
                            homing_phase = CODE_BACKOFF;
                        end
                    end
                end else begin
                    for (j = 0; j < JOINTS; j++) begin
                        if (backoff_steps_done < BACKOFF_CNT_W'(backoff_set[j])) pulses[j] = 1'b1;
                    end
                    if (backoff_steps_done != '1) backoff_steps_done++;
                    if (pulses == '0) homing_phase = CODE_COMPLETE;
                end
            end
        end
        res.step_pulses    = pulses;
        res.directions     = dir_level;
        res.phase          = homing_phase;
        res.start_accepted = took_start;
        res.finished       = (homing_phase == CODE_COMPLETE || homing_phase == CODE_FAILED);
    endtask

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    // Predict on each input beat, compare on each result beat
    always @(posedge aclk) begin : watch_streams
        result_t want;
        result_t got;
        if (!aresetn) begin
            reset_homing();
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_DELAY:    delay_set      = cfg_wdata[DELAY_W-1:0];
                    REG_MAX_SEEK:      seek_limit     = cfg_wdata[MAX_SEEK_W-1:0];
                    REG_SEEK_DIRS:     seek_dir_set   = cfg_wdata[JOINTS-1:0];
                    REG_BACKOFF_ONE:   backoff_set[0] = cfg_wdata[BACKOFF_W-1:0];
                    REG_BACKOFF_TWO:   backoff_set[1] = cfg_wdata[BACKOFF_W-1:0];
                    REG_BACKOFF_THREE: backoff_set[2] = cfg_wdata[BACKOFF_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_homing(s_axis_tuser, s_axis_tdata[JOINTS-1:0], want);
                expected_reports.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, got);
                    mismatch_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("step_pulses", want.step_pulses, got.step_pulses);
                    check_field("directions", want.directions, got.directions);
                    check_field("phase", want.phase, got.phase);
                    check_field("start_accepted", 3'(want.start_accepted),
                                3'(got.start_accepted));
                    check_field("finished", 3'(want.finished), 3'(got.finished));
                end
            end
        end
        reports_awaited = expected_reports.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the homing sequencer: clock, reset, stimulus, result drain and verdict.
module testbench;
    import tahs_pkg::*;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;   // [2:0] limit_switches
    logic                  s_axis_tuser  = 1'b0; // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] step_pulses, [5:3] directions, [8:6] phase, [9] start_accepted, [10] finished
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int mismatch_total;
    int reports_awaited;
    int beats_sent     = 0;
    int step_span      = 1;
    int backoff_peak   = 2;
    bit steady_sender  = 1'b0;
    bit squeeze_req    = 1'b0;
    bit squeeze_done   = 1'b0;

    logic [CFG_IDX_W-1:0] backoff_regs [JOINTS] =
        '{REG_BACKOFF_ONE, REG_BACKOFF_TWO, REG_BACKOFF_THREE};

    always #10 aclk = ~aclk;

    three_axis_homing_sequencer u_dut (.*);

    homing_checker u_checker (.*);

    // Gap before a beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_sender || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one beat and hold it until taken
    task automatic send_beat(input logic act, input logic [JOINTS-1:0] sw);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_TDATA_W'(sw);
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        beats_sent++;
    endtask

    // Write a register once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        s_axis_tvalid <= 1'b0;
        while (reports_awaited != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure_random();
        int unsigned delay_val, count;
        int          j;
        delay_val = $urandom_range(0, 3);
        write_reg(REG_STEP_DELAY, delay_val);
        step_span = (delay_val == 0) ? 1 : delay_val;
        // short limits make some seeks time out
        write_reg(REG_MAX_SEEK, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                             : $urandom_range(12, 60));
        write_reg(REG_SEEK_DIRS, $urandom_range(0, 7));
        backoff_peak = 0;
        for (j = 0; j < JOINTS; j++) begin
            count = $urandom_range(0, 6);
            write_reg(backoff_regs[j], count);
            if (count > backoff_peak) backoff_peak = count;
        end
    endtask

    // One homing run: start, then ticks whose switches close at random points
    task automatic run_homing(input int tick_cap);
        int                hit_at [JOINTS];
        int                last_hit, n_ticks, t, j;
        logic [JOINTS-1:0] sw;
        last_hit = 0;
        for (j = 0; j < JOINTS; j++) begin
            hit_at[j] = $urandom_range(0, 10 * step_span);
            if (hit_at[j] > last_hit) last_hit = hit_at[j];
        end
        n_ticks = last_hit + (backoff_peak + 2) * step_span + $urandom_range(0, 3);
        // cut some runs short so the next start lands mid-sequence
        if ($urandom_range(0, 9) == 0) n_ticks = $urandom_range(1, n_ticks);
        if (n_ticks > tick_cap) n_ticks = tick_cap;
        steady_sender = ($urandom_range(0, 3) == 0);
        send_beat(ACT_START, JOINTS'($urandom));
        for (t = 1; t <= n_ticks; t++) begin
            for (j = 0; j < JOINTS; j++) sw[j] = (t >= hit_at[j]);
            if ($urandom_range(0, 9) == 0) sw = sw ^ JOINTS'($urandom_range(1, 7));
            if ($urandom_range(0, 39) == 0) send_beat(ACT_START, JOINTS'($urandom));
            send_beat(ACT_TICK, sw);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 5);
        steady_sender = 1'b0;
        repeat (n) send_beat(1'($urandom_range(0, 1)), JOINTS'($urandom));
    endtask

    initial begin : stimulus
        int round, round_base;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: backoff counts 0/1/2 so joints drop out one by one
        write_reg(REG_BACKOFF_ONE, 0);
        write_reg(REG_BACKOFF_TWO, 1);
        write_reg(REG_BACKOFF_THREE, 2);
        send_beat(ACT_TICK, 3'b111);   // tick while idle
        send_beat(ACT_START, 3'b000);
        send_beat(ACT_START, 3'b111);  // refused during seek
        send_beat(ACT_TICK, 3'b111);   // default delay, no step yet
        send_beat(ACT_TICK, 3'b000);
        write_reg(REG_STEP_DELAY, 0);  // change delay mid-seek
        send_beat(ACT_TICK, 3'b001);
        send_beat(ACT_TICK, 3'b000);
        send_beat(ACT_TICK, 3'b110);   // all latched, enter backoff
        send_beat(ACT_START, 3'b101);  // refused during backoff
        send_beat(ACT_TICK, 3'b010);
        send_beat(ACT_TICK, 3'b101);
        send_beat(ACT_TICK, 3'b000);   // complete
        send_beat(ACT_TICK, 3'b111);   // tick while complete
        write_reg(REG_MAX_SEEK, 0);
        send_beat(ACT_START, 3'b000);
        send_beat(ACT_TICK, 3'b000);   // seek timeout on first step
        send_beat(ACT_TICK, 3'b111);   // tick while failed
        write_reg(REG_SEEK_DIRS, 5);
        write_reg(REG_MAX_SEEK, 20'hFFFFF);
        write_reg(REG_STEP_DELAY, 2);
        send_beat(ACT_START, 3'b111);  // restart from failed
        repeat (2) send_beat(ACT_TICK, 3'b111);
        repeat (6) send_beat(ACT_TICK, JOINTS'($urandom));

        // random part; the drain side stalls hard once, while the first round streams
        for (round = 0; round < 10; round++) begin
            if (round == 3) begin
                // widest delay: no step within the run
                write_reg(REG_STEP_DELAY, 16'hFFFF);
                write_reg(REG_MAX_SEEK, 20'hFFFFF);
                step_span = 16'hFFFF;
                run_homing(40);
            end
            if (round == 6) begin
                // widest backoff, cut short by the next settings
                write_reg(REG_STEP_DELAY, 0);
                step_span = 1;
                for (int j = 0; j < JOINTS; j++) write_reg(backoff_regs[j], 16'hFFFF);
                backoff_peak = 16'hFFFF;
                run_homing(120);
            end
            configure_random();
            if (round == 0) squeeze_req = 1'b1;
            round_base = beats_sent;
            while (beats_sent - round_base < 130) begin
                if ($urandom_range(0, 7) == 0) send_noise();
                else run_homing(1000);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (reports_awaited != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatch_total == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: random stalls, ready stretches, one long hold-off
    initial begin : result_drain
        int hold, roll;
        @(negedge aclk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge aclk);
                squeeze_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    m_axis_tready <= 1'b1;
                    @(negedge aclk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ((roll < 96) ? $urandom_range(1, 3) : $urandom_range(20, 80))
                        @(negedge aclk);
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
